[hdl/fdsa_pkg.sv]
// Package for the stack-machine ALU: sizes, opcodes, status codes and word types.
// Used by every module in the hdl folder except fdsa_div; depends on nothing else.
`timescale 1ns / 1ps
package fdsa_pkg;
  localparam int StackDepth = 64;
  localparam int MemWords   = 256;
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int SaW        = $clog2(StackDepth);
  localparam int MaW        = (MemWords > 1) ? $clog2(MemWords) : 1;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
    OP_DIV = 4'd4, OP_DUP = 4'd5, OP_DROP = 4'd6, OP_SWAP = 4'd7,
    OP_OVER = 4'd8, OP_EQ = 4'd9, OP_LT = 4'd10, OP_GT = 4'd11,
    OP_PRINT = 4'd12, OP_FETCH = 4'd13, OP_STORE = 4'd14, OP_EOL = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_DIVZERO = 3'd3,
    ST_DIVOVF = 3'd4, ST_BADADDR = 3'd5, ST_SKIP = 3'd6
  } status_e;

  typedef struct packed {
    logic [3:0]  op;
    logic signed [31:0] literal;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic signed [31:0] value;
    logic        printed;
    logic [6:0]  depth;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture input word
    logic pop_b;     // pop into b
    logic pop_a;     // pop into a
    logic rd_top;    // read stack top into the top register
    logic mem_rd;    // read data memory at a; unused, the datapath reads it every cycle
    logic div_start; // start divider
    logic push;      // push push_sel value
    logic [2:0] push_sel;
    logic mem_wr;    // write a to memory at b
    logic set_sp0;   // empty the stack
    logic clr_step;  // clear memory entry at clear counter
  } cmd_t;

  localparam logic [2:0] PS_LIT = 3'd0, PS_ALU = 3'd1, PS_A = 3'd2, PS_B = 3'd3,
                         PS_MEM = 3'd4, PS_DIV = 3'd5;

  typedef struct packed {
    logic [3:0] op;
    logic empty;
    logic full;
    logic b_zero;
    logic div_ovf;
    logic addr_bad;
    logic div_done;
    logic clr_done;
    logic [SpW-1:0] sp;
  } stat_t;
endpackage

[hdl/fdsa_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Does not depend on fdsa_pkg; no package items used.
`timescale 1ns / 1ps
module fdsa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    shifted = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[31] ? (~a_i + 32'd1) : a_i;
      den_d = b_i[31] ? (~b_i + 32'd1) : b_i;
      neg_d = a_i[31] ^ b_i[31];
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q && (cnt_q == 6'd0);
  assign q_o = neg_q ? (~quo_q + 32'd1) : quo_q;
endmodule

[hdl/fdsa_datapath.sv]
// Datapath: data stack memory, word memory, operand registers, ALU and divider.
// Depends on fdsa_pkg and fdsa_div.
`timescale 1ns / 1ps
module fdsa_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  fdsa_pkg::in_word_t in_i,
  input  fdsa_pkg::cmd_t cmd_i,
  output fdsa_pkg::stat_t stat_o,
  output logic [31:0] a_o,
  output logic [31:0] top_o
);
  import fdsa_pkg::*;

  logic [31:0] stack_mem [StackDepth];
  logic [31:0] data_mem [MemWords];
  logic [SpW-1:0] sp_q, sp_d;
  logic [MaW:0] clr_q;
  in_word_t in_q;
  logic [31:0] a_q, b_q, top_q, mrd_q, push_val, alu, q;
  logic [31:0] rd_data;
  logic [31:0] maddr;
  logic div_done;
  logic [SpW-1:0] rd_idx;

  fdsa_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(q)
  );

  always_comb begin
    unique case (in_q.op)
      OP_ADD: alu = a_q + b_q;
      OP_SUB: alu = a_q - b_q;
      OP_MUL: alu = a_q * b_q;
      OP_EQ:  alu = {32{a_q == b_q}};
      OP_LT:  alu = {32{$signed(a_q) < $signed(b_q)}};
      OP_GT:  alu = {32{$signed(a_q) > $signed(b_q)}};
      default: alu = a_q;
    endcase
  end

  always_comb begin
    case (cmd_i.push_sel)
      PS_LIT:  push_val = in_q.literal;
      PS_ALU:  push_val = alu;
      PS_B:    push_val = b_q;
      PS_MEM:  push_val = mrd_q;
      PS_DIV:  push_val = q;
      default: push_val = a_q;
    endcase
  end

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.pop_a || cmd_i.pop_b) sp_d = sp_q - SpW'(1);
    if (cmd_i.push) sp_d = sp_q + SpW'(1);
    if (cmd_i.set_sp0) sp_d = '0;
  end

  // One read port: the popped entry, or the top after the step.
  assign rd_idx = sp_d - SpW'(1);

  // Store takes its address from the top of stack, fetch from its only operand.
  assign maddr = (in_q.op == OP_STORE) ? b_q : a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      clr_q <= '0;
    end else begin
      sp_q <= sp_d;
      if (cmd_i.clr_step) clr_q <= clr_q + (MaW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) stack_mem[sp_q[SaW-1:0]] <= push_val;
    rd_data <= stack_mem[rd_idx[SaW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) data_mem[clr_q[MaW-1:0]] <= '0;
    else if (cmd_i.mem_wr) data_mem[maddr[MaW-1:0]] <= a_q;
    mrd_q <= data_mem[maddr[MaW-1:0]];
  end

  // Right after a push rd_data is stale; the controller waits for it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_i;
    if (cmd_i.pop_b) b_q <= rd_data;
    if (cmd_i.pop_a) a_q <= rd_data;
    if (cmd_i.rd_top) top_q <= (sp_q == '0) ? 32'd0 : rd_data;
  end

  assign stat_o.op       = in_q.op;
  assign stat_o.empty    = (sp_q == '0);
  assign stat_o.full     = (sp_q >= SpW'(StackDepth));
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.div_ovf  = (a_q == 32'h8000_0000) && (b_q == 32'hFFFF_FFFF);
  assign stat_o.addr_bad = maddr[31] || (33'(maddr) >= 33'(MemWords));
  assign stat_o.div_done = div_done;
  assign stat_o.clr_done = (clr_q == (MaW+1)'(MemWords));
  assign stat_o.sp       = sp_q;
  assign a_o   = a_q;
  assign top_o = top_q;
endmodule

[hdl/fdsa_ctrl.sv]
// Controller: clears word memory after reset, then sequences pops, operation, pushes and result for each op word.
// Depends on fdsa_pkg.
`timescale 1ns / 1ps
module fdsa_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  fdsa_pkg::stat_t stat_i,
  output fdsa_pkg::cmd_t cmd_o,
  output logic [2:0] status_o,
  output logic printed_o,
  output logic use_a_o
);
  import fdsa_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_DEC = 4'd2, S_POPB = 4'd3,
                         S_POPA = 4'd4, S_EXEC = 4'd5, S_DIV = 4'd6, S_MEM = 4'd7,
                         S_PUSH = 4'd8, S_TOP = 4'd9, S_TOPW = 4'd10, S_OUT = 4'd11;

  logic [3:0] state_q, state_d;
  logic [2:0] err_q, err_d, stat_q, stat_d;
  logic [1:0] pn_q, pn_d;   // push number within dup/swap/over
  logic prt_q, prt_d;
  logic [2:0] sel;
  logic       two;

  assign two = !(stat_i.op == OP_DUP || stat_i.op == OP_DROP ||
                 stat_i.op == OP_PRINT || stat_i.op == OP_FETCH);

  always_comb begin
    case (stat_i.op)
      OP_PUSH:  sel = PS_LIT;
      OP_DIV:   sel = PS_DIV;
      OP_FETCH: sel = PS_MEM;
      OP_DUP:   sel = PS_A;
      OP_SWAP:  sel = (pn_q == 2'd0) ? PS_B : PS_A;
      OP_OVER:  sel = (pn_q == 2'd1) ? PS_B : PS_A;
      default:  sel = PS_ALU;
    endcase
  end

  always_comb begin
    state_d = state_q; err_d = err_q; stat_d = stat_q; pn_d = pn_q; prt_d = prt_q;
    cmd_o = '0;
    cmd_o.push_sel = sel;
    unique case (state_q)
      S_CLR: begin
        if (stat_i.clr_done) state_d = S_IDLE;
        else cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          pn_d = '0; prt_d = 1'b0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (stat_i.op == OP_EOL) begin
          stat_d = err_q;
          if (err_q != ST_OK) cmd_o.set_sp0 = 1'b1;
          err_d = ST_OK;
          state_d = S_TOP;
        end else if (err_q != ST_OK) begin
          stat_d = ST_SKIP;
          state_d = S_TOP;
        end else if (stat_i.op == OP_PUSH) begin
          state_d = S_PUSH;
        end else if (two) begin
          state_d = S_POPB;
        end else begin
          state_d = S_POPA;
        end
      end
      S_POPB: begin
        if (stat_i.empty) begin
          err_d = ST_EMPTY; state_d = S_TOP;
        end else begin
          cmd_o.pop_b = 1'b1; state_d = S_POPA;
        end
      end
      S_POPA: begin
        if (stat_i.empty) begin
          err_d = ST_EMPTY; state_d = S_TOP;
        end else begin
          cmd_o.pop_a = 1'b1; state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_PUSH;
        case (stat_i.op)
          OP_DIV: begin
            if (stat_i.b_zero) begin
              err_d = ST_DIVZERO; state_d = S_TOP;
            end else if (stat_i.div_ovf) begin
              err_d = ST_DIVOVF; state_d = S_TOP;
            end else begin
              cmd_o.div_start = 1'b1; state_d = S_DIV;
            end
          end
          OP_FETCH, OP_STORE: begin
            if (stat_i.addr_bad) begin
              err_d = ST_BADADDR; state_d = S_TOP;
            end else if (stat_i.op == OP_STORE) begin
              cmd_o.mem_wr = 1'b1; state_d = S_TOP;
            end else begin
              state_d = S_MEM;
            end
          end
          OP_DROP: state_d = S_TOP;
          OP_PRINT: begin
            prt_d = 1'b1; state_d = S_TOP;
          end
          default: ;
        endcase
      end
      S_DIV: if (stat_i.div_done) state_d = S_PUSH;
      S_MEM: state_d = S_PUSH;
      S_PUSH: begin
        if (stat_i.full) begin
          err_d = ST_FULL; state_d = S_TOP;
        end else begin
          cmd_o.push = 1'b1;
          pn_d = pn_q + 2'd1;
          if ((stat_i.op == OP_DUP || stat_i.op == OP_SWAP) && pn_q == 2'd0)
            state_d = S_PUSH;
          else if (stat_i.op == OP_OVER && pn_q != 2'd2) state_d = S_PUSH;
          else state_d = S_TOP;
        end
      end
      S_TOP: state_d = S_TOPW;
      S_TOPW: begin
        cmd_o.rd_top = 1'b1;
        if (stat_i.op != OP_EOL && err_q != ST_SKIP) stat_d = err_q;
        if (stat_i.op != OP_EOL && stat_q == ST_SKIP) stat_d = ST_SKIP;
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; err_q <= ST_OK; stat_q <= ST_OK; pn_q <= '0; prt_q <= 1'b0;
    end else begin
      state_q <= state_d; err_q <= err_d; pn_q <= pn_d; prt_q <= prt_d;
      stat_q <= (state_q == S_IDLE) ? ST_OK : stat_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = stat_q;
  assign printed_o   = prt_q;
  assign use_a_o     = prt_q;
endmodule

[hdl/forth_data_stack_alu_unit.sv]
// Top level of the stack-machine ALU; joins controller and datapath.
// Depends on fdsa_pkg, fdsa_ctrl, fdsa_datapath and fdsa_div.
`timescale 1ns / 1ps
// One op word is taken at a time and its result word is shown until taken.
// Each op word steps through the single-port stack one access at a time (a pop,
// a push, the top read), and a divide also waits for the bit-serial divider.
// After reset the word memory is cleared one entry per cycle, and no op word
// is taken during that pass. The stack holds 64 words.
module forth_data_stack_alu_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  fdsa_pkg::in_word_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output fdsa_pkg::out_word_t out_data_o
);
  import fdsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [31:0] a_val, top_val;
  logic [2:0]  status;
  logic        printed, use_a;

  fdsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd), .status_o(status), .printed_o(printed), .use_a_o(use_a)
  );

  fdsa_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .stat_o(stat),
    .a_o(a_val), .top_o(top_val)
  );

  assign out_data_o.status  = status;
  assign out_data_o.value   = use_a ? a_val : top_val;
  assign out_data_o.printed = printed;
  assign out_data_o.depth   = 7'(stat.sp);

  // The stack pointer never exceeds its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.sp <= SpW'(StackDepth))
    else $error("stack pointer beyond depth");
  // Input and output never both open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input taken while result pending");
  // A printed result always reports ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && printed |-> status == ST_OK)
    else $error("printed with error status");
endmodule
